[src/ffst_pkg.sv]
// ----------------------------------------------------------------------------
// ffst_pkg: shared types and constants for the first-free slot tag table
// Request and response beat layouts, operation and status codes, controller
// state encoding, and the command/status bundles between controller and
// datapath.
// ----------------------------------------------------------------------------
package ffst_pkg;

    // Widths fixed by the request and response layouts.
    localparam int ID_BITS     = 16;
    localparam int ROW_FIELD_W = 2;
    localparam int COL_FIELD_W = 3;
    localparam int STATUS_W    = 2;

    // Operation codes.
    localparam logic OP_PLACE   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_PLACED   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RELEASED = 2'd2;
    localparam logic [STATUS_W-1:0] ST_MISSING  = 2'd3;

    typedef struct packed {
        logic               opcode;
        logic [ID_BITS-1:0] vehicle_id;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [ROW_FIELD_W-1:0] slot_row;
        logic [COL_FIELD_W-1:0] slot_col;
    } t_rsp;

    typedef enum logic {
        S_IDLE,
        S_COMMIT
    } t_state;

    // Controller to datapath.
    typedef struct packed {
        logic load_req;  // capture request and register the hit vector
        logic commit;    // update the table and load the response register
    } t_ctrl_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic out_free;  // response register can take a new beat this cycle
    } t_dp_status;

endpackage

[src/first_free_slot_tag_table_top.sv]
// ----------------------------------------------------------------------------
// first_free_slot_tag_table_top: slot allocator with tag match
// Top level joining the request sequencer and the slot table datapath.
// ----------------------------------------------------------------------------
// Usage:
// Requests come in on the input channel (i_in_valid / o_in_ready, payload
// i_in_data) and each produces exactly one response beat on the output
// channel (o_out_valid / i_out_ready, payload o_out_data).
// A place request writes the identifier into the first free slot, scanning
// row 0 first and column 0 first within a row; a release frees the first live
// slot whose tag equals the identifier, in the same order. The response gives
// the status and the slot position, with position zero on full or not found.
// Timing: a request is taken in S_IDLE, when the hit vector of all slots is
// registered, and committed in S_COMMIT, when the first hit is picked, the
// slot is updated and the response register is loaded; the response is valid
// from that register. The block takes no new request until the last one has
// committed, as the compare step is followed by the priority-select and
// write step.
// A finished response may wait in its register while the next request is
// taken; if the receiver still stalls at commit, the commit and hence the
// next acceptance wait until the response beat is taken.
// Reset (synchronous, active low) frees every slot at once and drops any
// pending response; stored tags are left as they are.
// ----------------------------------------------------------------------------
module first_free_slot_tag_table_top
    import ffst_pkg::*;
#(
    parameter int ROW_COUNT = 4,
    parameter int COL_COUNT = 8,
    parameter int TAG_BITS  = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_req i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_rsp o_out_data
);

    // Command and status bundles between the sequencer and the datapath.
    t_ctrl_cmd  w_cmd;
    t_dp_status w_status;

    ffst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    ffst_dp #(
        .ROW_COUNT (ROW_COUNT),
        .COL_COUNT (COL_COUNT),
        .TAG_BITS  (TAG_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_in_data),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

[src/ffst_ctrl.sv]
// ----------------------------------------------------------------------------
// ffst_ctrl: request sequencer
// Two-state controller: accepts a request, then commits it once the response
// register can take the result.
// ----------------------------------------------------------------------------
module ffst_ctrl
    import ffst_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_ctrl_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready     = 1'b0;
        o_cmd.load_req = 1'b0;
        o_cmd.commit   = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready     = 1'b1;
                o_cmd.load_req = i_in_valid;
            end
            S_COMMIT: begin
                o_cmd.commit = i_status.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

[src/ffst_dp.sv]
// ----------------------------------------------------------------------------
// ffst_dp: slot table datapath
// Holds the tags and valid marks, compares every slot against the request,
// picks the first hit in row-major order, updates the slot and registers the
// response beat.
// ----------------------------------------------------------------------------
module ffst_dp
    import ffst_pkg::*;
#(
    parameter int ROW_COUNT = 4,
    parameter int COL_COUNT = 8,
    parameter int TAG_BITS  = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_req       i_req,
    input  t_ctrl_cmd  i_cmd,
    output t_dp_status o_status,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_rsp       o_out_data
);

    localparam int SLOTS = ROW_COUNT * COL_COUNT;

    logic [TAG_BITS-1:0] r_tag [SLOTS];
    logic [SLOTS-1:0]    r_valid;
    logic [SLOTS-1:0]    r_hit;
    logic [SLOTS-1:0]    n_hit;
    logic                r_op;
    logic [TAG_BITS-1:0] r_id;
    logic [TAG_BITS-1:0] w_id;
    logic                r_out_valid;
    t_rsp                r_out;
    t_rsp                n_out;
    logic [SLOTS-1:0]    w_first;
    logic                w_found;
    logic [ROW_FIELD_W-1:0] w_row;
    logic [COL_FIELD_W-1:0] w_col;

    // The identifier is cut or zero-extended to the stored tag width.
    assign w_id = TAG_BITS'(i_req.vehicle_id);

    // Per-slot candidate: a free slot for a place, a live matching tag for a release.
    always_comb begin
        for (int k = 0; k < SLOTS; k++) begin
            if (i_req.opcode == OP_PLACE) begin
                n_hit[k] = !r_valid[k];
            end else begin
                n_hit[k] = r_valid[k] && (r_tag[k] == w_id);
            end
        end
    end

    // First hit, row 0 and column 0 first.
    always_comb begin
        w_first = '0;
        w_found = 1'b0;
        w_row   = '0;
        w_col   = '0;
        for (int r = ROW_COUNT - 1; r >= 0; r--) begin
            for (int c = COL_COUNT - 1; c >= 0; c--) begin
                if (r_hit[r * COL_COUNT + c]) begin
                    w_first = '0;
                    w_first[r * COL_COUNT + c] = 1'b1;
                    w_found = 1'b1;
                    w_row   = ROW_FIELD_W'(r);
                    w_col   = COL_FIELD_W'(c);
                end
            end
        end
    end

    always_comb begin
        n_out.slot_row = w_row;
        n_out.slot_col = w_col;
        if (r_op == OP_PLACE) begin
            n_out.status = w_found ? ST_PLACED : ST_FULL;
        end else begin
            n_out.status = w_found ? ST_RELEASED : ST_MISSING;
        end
    end

    // Control state: valid marks and response valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                for (int k = 0; k < SLOTS; k++) begin
                    if (w_first[k]) begin
                        r_valid[k] <= (r_op == OP_PLACE);
                    end
                end
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_hit <= n_hit;
            r_op  <= i_req.opcode;
            r_id  <= w_id;
        end
        if (i_cmd.commit) begin
            r_out <= n_out;
            for (int k = 0; k < SLOTS; k++) begin
                if (w_first[k] && (r_op == OP_PLACE)) begin
                    r_tag[k] <= r_id;
                end
            end
        end
    end

    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_out_data        = r_out;

endmodule
